// ===== src/pngf_pkg.sv =====
// ----------------------------------------------------------------------------
// pngf_pkg: shared types, codes and prediction functions
// Filter codes, register map and the byte predictors of the row filter.
// ----------------------------------------------------------------------------
package pngf_pkg;

  localparam int MAX_ROW_BYTES_DEF = 8192;
  localparam int MAX_BPP_DEF       = 8;

  localparam int BPP_W    = 4;
  localparam int ROWB_W   = 14;
  localparam int CFG_AW   = 4;
  localparam int CFG_DW   = 32;

  typedef enum logic [1:0] {
    FILT_SUB   = 2'd0,
    FILT_UP    = 2'd1,
    FILT_AVG   = 2'd2,
    FILT_PAETH = 2'd3
  } filt_t;

  typedef enum logic [1:0] {
    REG_DIRECTION = 2'd0,
    REG_BPP       = 2'd1,
    REG_ROW_BYTES = 2'd2
  } reg_idx_t;

  localparam logic DIR_ENCODE = 1'b0;
  localparam logic DIR_DECODE = 1'b1;

  // one item held in the compute stage (parameter-free fields only)
  typedef struct packed {
    logic [7:0] data;
    logic [1:0] ftype;
    logic       first_row;
    logic       has_left;
    logic       last;
  } s1_item_t;

  // Paeth: ties go left, then up, then upper-left
  function automatic logic [7:0] paeth_pick(input logic [7:0] a, input logic [7:0] b,
                                            input logic [7:0] c);
    logic signed [10:0] p;
    logic signed [10:0] da;
    logic signed [10:0] db;
    logic signed [10:0] dc;
    logic [7:0]         res;
    p  = $signed({3'b000, a}) + $signed({3'b000, b}) - $signed({3'b000, c});
    da = p - $signed({3'b000, a});
    db = p - $signed({3'b000, b});
    dc = p - $signed({3'b000, c});
    if (da < 0) da = -da;
    if (db < 0) db = -db;
    if (dc < 0) dc = -dc;
    if (da <= db && da <= dc) res = a;
    else if (db <= dc)        res = b;
    else                      res = c;
    return res;
  endfunction

  function automatic logic [7:0] predict(input logic [1:0] ftype, input logic [7:0] left,
                                         input logic [7:0] up, input logic [7:0] upleft);
    logic [8:0] sum;
    logic [7:0] res;
    sum = {1'b0, left} + {1'b0, up};
    unique case (filt_t'(ftype))
      FILT_SUB:   res = left;
      FILT_UP:    res = up;
      FILT_AVG:   res = sum[8:1];
      FILT_PAETH: res = paeth_pick(left, up, upleft);
      default:    res = left;
    endcase
    return res;
  endfunction

endpackage

// ===== src/pngf_line_buf.sv =====
// ----------------------------------------------------------------------------
// pngf_line_buf: previous-row line buffer
// Single-port-write, single-read synchronous RAM with a registered read,
// and a bypass for a write and read of the same entry in the same cycle.
// ----------------------------------------------------------------------------
module pngf_line_buf #(
  parameter int DEPTH = pngf_pkg::MAX_ROW_BYTES_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_r;
  logic [7:0] byp_data_r;
  logic       byp_hit_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r  <= mem[rd_addr];
    byp_data_r <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_hit_r <= 1'b0;
    end else begin
      byp_hit_r <= wr_en && (wr_addr == rd_addr);
    end
  end

  assign rd_data = byp_hit_r ? byp_data_r : rd_data_r;

endmodule

// ===== src/pngf_pixel_core.sv =====
// ----------------------------------------------------------------------------
// pngf_pixel_core: prediction and filter arithmetic
// Holds the left and upper-left history per byte slot, forms the
// predictor and applies or removes it.
// ----------------------------------------------------------------------------
module pngf_pixel_core #(
  parameter int MAX_BPP = pngf_pkg::MAX_BPP_DEF,
  parameter int SW      = (MAX_BPP > 1) ? $clog2(MAX_BPP) : 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pngf_pkg::s1_item_t   item,
  input  logic [SW-1:0]        slot,
  input  logic [7:0]           up_mem,
  input  logic                 direction,
  input  logic                 commit,
  output logic [7:0]           result,
  output logic [7:0]           raw
);

  logic [7:0] left_hist_r [MAX_BPP];
  logic [7:0] ul_hist_r   [MAX_BPP];
  logic [7:0] left;
  logic [7:0] up;
  logic [7:0] upleft;
  logic [7:0] pred;

  always_comb begin
    up     = item.first_row ? 8'd0 : up_mem;
    left   = item.has_left ? left_hist_r[slot] : 8'd0;
    upleft = (item.has_left && !item.first_row) ? ul_hist_r[slot] : 8'd0;
    pred   = pngf_pkg::predict(item.ftype, left, up, upleft);
    if (direction == pngf_pkg::DIR_ENCODE) begin
      result = item.data - pred;
      raw    = item.data;
    end else begin
      result = item.data + pred;
      raw    = result;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_BPP; i++) begin
        left_hist_r[i] <= 8'd0;
        ul_hist_r[i]   <= 8'd0;
      end
    end else if (commit) begin
      left_hist_r[slot] <= raw;
      ul_hist_r[slot]   <= up;
    end
  end

endmodule

// ===== src/png_scanline_filter_unfilter.sv =====
// ----------------------------------------------------------------------------
// png_scanline_filter_unfilter: PNG row filter / unfilter, one byte per item
// Applies or removes Sub, Up, Average and Paeth filtering on a byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one scanline byte per item,
//   with its filter type and an image-start flag. Output channel
//   (out_valid / out_stall) returns one byte per item plus a row-end flag.
//   Configuration (direction, bytes per pixel, row length) is to be written over
//   the APB port only while no item is in flight; the block does not enforce this. pready is tied high.
// Path: an accepted item is registered in the compute stage, then in the
//   output register. Throughput: one item per cycle unless out_stall holds
//   a full output register. The previous-row byte is read from RAM at accept
//   time and re-read while the item waits; the row buffer write happens when
//   the item leaves the compute stage, and a same-entry read in that cycle uses the bypass register.
// Reset (rst_n, synchronous): config returns to encode, 1 byte/pixel, row
//   of 1 byte; column and slot counters clear, the first row reads zero as
//   its previous row. The line buffer itself is not cleared.
// Stall: when out_stall holds a full output register, the compute stage
//   keeps its item and in_stall rises in the same cycle.
// ----------------------------------------------------------------------------
module png_scanline_filter_unfilter #(
  parameter int MAX_ROW_BYTES = pngf_pkg::MAX_ROW_BYTES_DEF,
  parameter int MAX_BPP       = pngf_pkg::MAX_BPP_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // input channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  in_data_byte,
  input  logic [1:0]                  in_filter_type,
  input  logic                        in_image_start,
  // result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [7:0]                  out_byte,
  output logic                        out_row_end,
  // config port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pngf_pkg::CFG_AW-1:0] paddr,
  input  logic [pngf_pkg::CFG_DW-1:0] pwdata,
  output logic [pngf_pkg::CFG_DW-1:0] prdata,
  output logic                        pready
);

  localparam int CW  = $clog2(MAX_ROW_BYTES);
  localparam int SW  = (MAX_BPP > 1) ? $clog2(MAX_BPP) : 1;
  localparam int LW0 = $clog2(MAX_ROW_BYTES + 1);
  localparam int LW  = (LW0 > pngf_pkg::ROWB_W) ? LW0 : pngf_pkg::ROWB_W;
  localparam int BW  = pngf_pkg::BPP_W;

  // ---- configuration registers ----
  logic                        dir_r;
  logic [BW-1:0]               bpp_r;
  logic [pngf_pkg::ROWB_W-1:0] row_bytes_r;
  logic                        cfg_wr;
  logic [1:0]                  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r       <= pngf_pkg::DIR_ENCODE;
      bpp_r       <= BW'(1);
      row_bytes_r <= pngf_pkg::ROWB_W'(1);
    end else if (cfg_wr) begin
      case (cfg_idx)
        pngf_pkg::REG_DIRECTION: dir_r       <= pwdata[0];
        pngf_pkg::REG_BPP:       bpp_r       <= pwdata[BW-1:0];
        pngf_pkg::REG_ROW_BYTES: row_bytes_r <= pwdata[pngf_pkg::ROWB_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      pngf_pkg::REG_DIRECTION: prdata = pngf_pkg::CFG_DW'(dir_r);
      pngf_pkg::REG_BPP:       prdata = pngf_pkg::CFG_DW'(bpp_r);
      pngf_pkg::REG_ROW_BYTES: prdata = pngf_pkg::CFG_DW'(row_bytes_r);
      default:                 prdata = '0;
    endcase
  end

  // clamp out-of-range settings
  logic [BW-1:0] bpp_eff;
  logic [BW-1:0] bpp_m1;
  logic [LW-1:0] rb_ext;
  logic [LW-1:0] len_eff;

  always_comb begin
    if (bpp_r == '0)              bpp_eff = BW'(1);
    else if (bpp_r > BW'(MAX_BPP)) bpp_eff = BW'(MAX_BPP);
    else                          bpp_eff = bpp_r;
    bpp_m1 = bpp_eff - BW'(1);
    rb_ext = LW'(row_bytes_r);
    if (rb_ext == '0)                     len_eff = LW'(1);
    else if (rb_ext > LW'(MAX_ROW_BYTES)) len_eff = LW'(MAX_ROW_BYTES);
    else                                  len_eff = rb_ext;
  end

  // ---- handshake / pipeline control ----
  logic s1_valid_r;
  logic out_valid_r;
  logic adv;
  logic in_acc;

  assign adv      = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !adv;
  assign in_acc   = in_valid && !in_stall;

  // ---- accept stage: column, slot and row-end sequencing ----
  logic [CW-1:0] column_r;
  logic          first_row_r;
  logic [SW-1:0] slot_cnt_r [MAX_BPP];
  logic [SW-1:0] slot_cur   [MAX_BPP];
  logic [CW-1:0] col_eff;
  logic          first_eff;
  logic          acc_last;
  logic [SW-1:0] slot_eff;
  logic          has_left_eff;

  always_comb begin
    col_eff      = in_image_start ? '0 : column_r;
    first_eff    = in_image_start || first_row_r;
    acc_last     = (LW'(col_eff) + LW'(1)) >= len_eff;
    has_left_eff = LW'(col_eff) >= LW'(bpp_eff);
    for (int k = 0; k < MAX_BPP; k++) begin
      slot_cur[k] = in_image_start ? '0 : slot_cnt_r[k];
    end
    slot_eff = slot_cur[bpp_m1[SW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_r    <= '0;
      first_row_r <= 1'b1;
    end else if (in_acc) begin
      column_r    <= acc_last ? '0 : col_eff + CW'(1);
      first_row_r <= acc_last ? 1'b0 : first_eff;
    end
  end

  // one slot counter per possible pixel size, counter k wraps at k+1
  for (genvar k = 0; k < MAX_BPP; k++) begin : g_slot
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        slot_cnt_r[k] <= '0;
      end else if (in_acc) begin
        if (acc_last || slot_cur[k] == SW'(k)) slot_cnt_r[k] <= '0;
        else                                   slot_cnt_r[k] <= slot_cur[k] + SW'(1);
      end
    end
  end

  // ---- compute stage registers ----
  pngf_pkg::s1_item_t s1_r;
  logic [CW-1:0]      s1_col_r;
  logic [SW-1:0]      s1_slot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r.data      <= in_data_byte;
      s1_r.ftype     <= in_filter_type;
      s1_r.first_row <= first_eff;
      s1_r.has_left  <= has_left_eff;
      s1_r.last      <= acc_last;
      s1_col_r       <= col_eff;
      s1_slot_r      <= slot_eff;
    end
  end

  // ---- line buffer: read at accept, re-read while the item waits ----
  logic [CW-1:0] rd_addr;
  logic [7:0]    up_mem;
  logic [7:0]    result;
  logic [7:0]    raw;

  assign rd_addr = in_acc ? col_eff : s1_col_r;

  pngf_line_buf #(
    .DEPTH (MAX_ROW_BYTES),
    .AW    (CW)
  ) u_line_buf (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (adv),
    .wr_addr (s1_col_r),
    .wr_data (raw),
    .rd_addr (rd_addr),
    .rd_data (up_mem)
  );

  pngf_pixel_core #(
    .MAX_BPP (MAX_BPP),
    .SW      (SW)
  ) u_pixel_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .item      (s1_r),
    .slot      (s1_slot_r),
    .up_mem    (up_mem),
    .direction (dir_r),
    .commit    (adv),
    .result    (result),
    .raw       (raw)
  );

  // ---- output register ----
  logic [7:0] out_byte_r;
  logic       out_row_end_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_byte_r    <= result;
      out_row_end_r <= s1_r.last;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_byte    = out_byte_r;
  assign out_row_end = out_row_end_r;

`ifndef NO_ASSERTIONS
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r)
    else $error("input stalled with room in the pipeline");

  a_slot_in_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> (BW'(s1_slot_r) < bpp_eff) || $changed(bpp_r))
    else $error("byte slot outside pixel");

  a_start_resets_row: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_image_start |=> s1_valid_r && s1_r.first_row && s1_col_r == '0)
    else $error("image start did not restart the row");

  a_row_end_wraps: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && acc_last |=> column_r == '0 && !first_row_r)
    else $error("row end did not wrap the column");
`endif

endmodule
